[src/dcmat_pkg.sv]
// Shared types and constants of the dual-channel moving-average threshold detector.
`timescale 1ns / 1ps

package dcmat_pkg;

    // Width of a mean result and of a threshold register.
    localparam int MEAN_W = 12;
    localparam int THR_W = 12;
    localparam logic [THR_W-1:0] THR_RESET = 12'd250;

    // Result word: mean_a, mean_b, press_a, press_b, padded to whole bytes.
    localparam int OUT_FIELDS_W = 2 * MEAN_W + 2;
    localparam int OUT_DATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Register port.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register select, taken from address bit 2.
    localparam logic REG_THRESHOLD_A = 1'b0;
    localparam logic REG_THRESHOLD_B = 1'b1;

    // Load strobes for the two stages behind the running sums.
    typedef struct packed {
        logic load_prod;
        logic load_out;
    } t_stage_ctl;

endpackage

[src/dcmat_cell.sv]
// One cell of the sample shift line: holds one sample pair and passes it on.
`timescale 1ns / 1ps

module dcmat_cell #(
    parameter int DATA_W = 24
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_shift,
    input  logic [DATA_W-1:0] i_data,
    output logic [DATA_W-1:0] o_data
);

    logic [DATA_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data <= '0;
        end else if (i_shift) begin
            r_data <= i_data;
        end
    end

    assign o_data = r_data;

endmodule

[src/dcmat_mean.sv]
// Per-channel lane: divides the running sum by the window length and compares it.
`timescale 1ns / 1ps

module dcmat_mean #(
    parameter int WINDOW      = 50,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                                      i_clk,
    input  dcmat_pkg::t_stage_ctl                     i_ctl,
    input  logic [SAMPLE_BITS+$clog2(WINDOW)-1:0]     i_sum,
    input  logic [dcmat_pkg::THR_W-1:0]               i_threshold,
    output logic [dcmat_pkg::MEAN_W-1:0]              o_mean,
    output logic                                      o_press
);

    import dcmat_pkg::*;

    localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW);
    localparam int SHIFT = SUM_W + $clog2(WINDOW);
    localparam int RECIP_W = SUM_W + 2;
    localparam int PROD_W = SUM_W + RECIP_W;
    // Rounded-up reciprocal; exact quotient for every sum below 2**SUM_W.
    localparam logic [63:0] RECIP_FULL = ((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1)
                                         / 64'(WINDOW);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

    logic [PROD_W-1:0]      r_prod;
    logic [SAMPLE_BITS-1:0] w_quot;
    logic [MEAN_W-1:0]      w_mean;
    logic [MEAN_W-1:0]      r_mean;
    logic                   r_press;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_prod) begin
            r_prod <= PROD_W'(i_sum) * PROD_W'(RECIP);
        end
    end

    assign w_quot = r_prod[SHIFT +: SAMPLE_BITS];
    assign w_mean = MEAN_W'(w_quot);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_out) begin
            r_mean  <= w_mean;
            r_press <= (w_mean > i_threshold);
        end
    end

    assign o_mean  = r_mean;
    assign o_press = r_press;

endmodule

[src/dual_channel_moving_average_threshold.sv]
// Top level of the dual-channel moving-average threshold detector.
`timescale 1ns / 1ps

// Each input word carries one sample of channel A and one of channel B. The pair enters a
// shift line of WINDOW cells that reset clears at once, and two running sums add the new
// sample and drop the one leaving the far end of the line. Each result word gives both
// window means (sum divided by WINDOW, truncated, with not-yet-filled slots counted as
// zero) and a press flag per channel that is set when the mean is strictly above that
// channel's threshold register. One word is taken per clock cycle, set by the single
// add-subtract update of the running sums, unless a low m_axis_tready has filled the stages.
// A word passes the sum registers, the reciprocal product and the scaled, compared output.
// The threshold registers sit at byte addresses 0 (channel A) and 4 (channel B), reset to
// 250; the user must write them only while the block is idle; the block does not enforce it.
module dual_channel_moving_average_threshold #(
    parameter int WINDOW      = 50,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // sample_a, sample_b
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]    s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // mean_a, mean_b, press_a, press_b
    output logic [dcmat_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [dcmat_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [dcmat_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [dcmat_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                  pready
);

    import dcmat_pkg::*;

    localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW);
    localparam int PAIR_W = 2 * SAMPLE_BITS;
    localparam int PAD_W = OUT_DATA_W - OUT_FIELDS_W;
    localparam logic [SUM_W-1:0] SUM_MAX = SUM_W'(WINDOW * ((1 << SAMPLE_BITS) - 1));

    // Stage valids and readiness.
    logic r_vld_sum;
    logic r_vld_prod;
    logic r_vld_out;
    logic w_rdy_sum;
    logic w_rdy_prod;
    logic w_rdy_out;
    logic w_accept;
    t_stage_ctl w_ctl;

    // Running sums and the shift line.
    logic [SUM_W-1:0]       r_sum_a;
    logic [SUM_W-1:0]       r_sum_b;
    logic [SUM_W-1:0]       n_sum_a;
    logic [SUM_W-1:0]       n_sum_b;
    logic [PAIR_W-1:0]      w_tap [0:WINDOW];
    logic [SAMPLE_BITS-1:0] w_new_a;
    logic [SAMPLE_BITS-1:0] w_new_b;
    logic [SAMPLE_BITS-1:0] w_old_a;
    logic [SAMPLE_BITS-1:0] w_old_b;

    // Configuration.
    logic [THR_W-1:0] r_thr_a;
    logic [THR_W-1:0] r_thr_b;
    logic             w_cfg_wr;

    // Lane results.
    logic [MEAN_W-1:0] w_mean_a;
    logic [MEAN_W-1:0] w_mean_b;
    logic              w_press_a;
    logic              w_press_b;

    // A stage may load when it is empty or its word moves on in this cycle.
    assign w_rdy_out  = !r_vld_out || m_axis_tready;
    assign w_rdy_prod = !r_vld_prod || w_rdy_out;
    assign w_rdy_sum  = !r_vld_sum || w_rdy_prod;
    assign s_axis_tready = w_rdy_sum;
    assign w_accept = s_axis_tvalid && w_rdy_sum;

    assign w_ctl.load_prod = w_rdy_prod;
    assign w_ctl.load_out  = w_rdy_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_sum  <= 1'b0;
            r_vld_prod <= 1'b0;
            r_vld_out  <= 1'b0;
        end else begin
            if (w_rdy_sum) begin
                r_vld_sum <= s_axis_tvalid;
            end
            if (w_rdy_prod) begin
                r_vld_prod <= r_vld_sum;
            end
            if (w_rdy_out) begin
                r_vld_out <= r_vld_prod;
            end
        end
    end

    assign w_tap[0] = s_axis_tdata[PAIR_W-1:0];

    genvar g;
    generate
        for (g = 0; g < WINDOW; g++) begin : g_cell
            dcmat_cell #(
                .DATA_W (PAIR_W)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_accept),
                .i_data  (w_tap[g]),
                .o_data  (w_tap[g+1])
            );
        end
    endgenerate

    assign w_new_a = w_tap[0][SAMPLE_BITS-1:0];
    assign w_new_b = w_tap[0][PAIR_W-1:SAMPLE_BITS];
    assign w_old_a = w_tap[WINDOW][SAMPLE_BITS-1:0];
    assign w_old_b = w_tap[WINDOW][PAIR_W-1:SAMPLE_BITS];

    // The true sum always fits, so wrapping intermediate arithmetic is harmless.
    assign n_sum_a = r_sum_a - SUM_W'(w_old_a) + SUM_W'(w_new_a);
    assign n_sum_b = r_sum_b - SUM_W'(w_old_b) + SUM_W'(w_new_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_a <= '0;
            r_sum_b <= '0;
        end else if (w_accept) begin
            r_sum_a <= n_sum_a;
            r_sum_b <= n_sum_b;
        end
    end

    dcmat_mean #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mean_a (
        .i_clk       (i_clk),
        .i_ctl       (w_ctl),
        .i_sum       (r_sum_a),
        .i_threshold (r_thr_a),
        .o_mean      (w_mean_a),
        .o_press     (w_press_a)
    );

    dcmat_mean #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mean_b (
        .i_clk       (i_clk),
        .i_ctl       (w_ctl),
        .i_sum       (r_sum_b),
        .i_threshold (r_thr_b),
        .o_mean      (w_mean_b),
        .o_press     (w_press_b)
    );

    assign m_axis_tvalid = r_vld_out;
    assign m_axis_tdata  = {PAD_W'(0), w_press_b, w_press_a, w_mean_b, w_mean_a};

    // Register port; the word address comes from bit 2.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr_a <= THR_RESET;
            r_thr_b <= THR_RESET;
        end else if (w_cfg_wr) begin
            if (paddr[2] == REG_THRESHOLD_A) begin
                r_thr_a <= pwdata[THR_W-1:0];
            end else begin
                r_thr_b <= pwdata[THR_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_THRESHOLD_A) begin
            prdata = APB_DATA_W'(r_thr_a);
        end else begin
            prdata = APB_DATA_W'(r_thr_b);
        end
    end

    a_accept_fills_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_vld_sum)
        else $error("accepted word did not reach the sum stage");

    a_sum_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sum_a <= SUM_MAX) && (r_sum_b <= SUM_MAX))
        else $error("running sum exceeds the window maximum");

    a_prod_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld_prod && w_rdy_out) |=> r_vld_out)
        else $error("product stage word lost before the output register");

    a_ready_when_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld_out |-> s_axis_tready)
        else $error("input stalled although the output register is free");

endmodule
